@@ rtl/rfs_pkg.sv @@
// Shared types and constants for the subsequence removal block.
`default_nettype none

package rfs_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_CLEAR       = 2'd0;
    localparam logic [OP_W-1:0] OP_APP_TARGET  = 2'd1;
    localparam logic [OP_W-1:0] OP_APP_PATTERN = 2'd2;
    localparam logic [OP_W-1:0] OP_RUN         = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APP_TARGET,
        CMD_APP_PATTERN,
        CMD_RUN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [WORD_W-1:0]  word;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH_RD,
        ST_MATCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/rfs_if.sv @@
// Handshake interfaces for the command and result channels.
`default_nettype none

interface rfs_item_if import rfs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] word;

    modport source (output valid, output op, output word, input ready);
    modport sink (input valid, input op, input word, output ready);
endinterface

interface rfs_result_if import rfs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value;
    logic                     last;
    logic                     found;
    logic                     empty_res;
    logic                     overflow;

    modport source (output valid, output value, output last, output found,
                    output empty_res, output overflow, input ready);
    modport sink (input valid, input value, input last, input found,
                  input empty_res, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/rfs_front.sv @@
// Front end: accepts command items, decodes the op code and queues them.
`default_nettype none

module rfs_front import rfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rfs_item_if.sink    cmd,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    cmd_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    cmd_t                decoded;
    logic                push;
    logic                pop;

    always_comb
    begin
        decoded.word = cmd.word;
        case (cmd.op)
            OP_CLEAR:       decoded.kind = CMD_CLEAR;
            OP_APP_TARGET:  decoded.kind = CMD_APP_TARGET;
            OP_APP_PATTERN: decoded.kind = CMD_APP_PATTERN;
            OP_RUN:         decoded.kind = CMD_RUN;
            default:        decoded.kind = CMD_RUN;
        endcase
    end

    assign cmd.ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_cmd     = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rfs_back.sv @@
// Back end: holds both stores, runs the search and compaction, emits results.
`default_nettype none

module rfs_back import rfs_pkg::*;
#(
    parameter int MAX_TARGET  = 64,
    parameter int MAX_PATTERN = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cmd_t          q_cmd,
    output logic          q_pop,
    rfs_result_if.source  result
);

    localparam int TCW = $clog2(MAX_TARGET + 1);
    localparam int TAW = $clog2(MAX_TARGET);
    localparam int PCW = $clog2(MAX_PATTERN + 1);
    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SW  = ((TCW > PCW) ? TCW : PCW) + 1;

    logic [WORD_W-1:0] target_mem  [MAX_TARGET];
    logic [WORD_W-1:0] pattern_mem [MAX_PATTERN];

    back_state_t       state_reg, state_next;
    logic [TCW-1:0]    tcount_reg, tcount_next;
    logic [PCW-1:0]    pcount_reg, pcount_next;
    logic              ovf_reg, ovf_next;
    logic              found_reg, found_next;
    logic [TCW-1:0]    start_reg, start_next;
    logic [PCW-1:0]    k_reg, k_next;
    logic [TCW-1:0]    idx_reg, idx_next;

    logic              t_we, t_re;
    logic [TAW-1:0]    t_waddr, t_raddr;
    logic [WORD_W-1:0] t_wdata, t_rdata_reg;
    logic              p_we, p_re;
    logic [PAW-1:0]    p_waddr, p_raddr;
    logic [WORD_W-1:0] p_rdata_reg;

    logic [SW-1:0]     tcnt_x, pcnt_x, start_x, k_x, idx_x;
    logic [SW-1:0]     sum_sk, sum_ip, sum_next_start;

    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_empty_reg, out_empty_next;
    logic                     out_found_reg, out_ovf_reg;
    logic                     out_free, load_out;

    assign tcnt_x         = SW'(tcount_reg);
    assign pcnt_x         = SW'(pcount_reg);
    assign start_x        = SW'(start_reg);
    assign k_x            = SW'(k_reg);
    assign idx_x          = SW'(idx_reg);
    assign sum_sk         = start_x + k_x;
    assign sum_ip         = idx_x + pcnt_x;
    assign sum_next_start = start_x + pcnt_x + 1'b1;
    assign out_free       = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        tcount_next    = tcount_reg;
        pcount_next    = pcount_reg;
        ovf_next       = ovf_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        t_we           = 1'b0;
        t_waddr        = '0;
        t_wdata        = q_cmd.word;
        t_re           = 1'b0;
        t_raddr        = '0;
        p_we           = 1'b0;
        p_waddr        = '0;
        p_re           = 1'b0;
        p_raddr        = '0;
        load_out       = 1'b0;
        out_value_next = '0;
        out_last_next  = 1'b1;
        out_empty_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_CLEAR:
                        begin
                            tcount_next = '0;
                            pcount_next = '0;
                            ovf_next    = 1'b0;
                        end
                        CMD_APP_TARGET:
                        begin
                            if (tcnt_x < SW'(MAX_TARGET))
                            begin
                                t_we        = 1'b1;
                                t_waddr     = tcount_reg[TAW-1:0];
                                tcount_next = tcount_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_APP_PATTERN:
                        begin
                            if (pcnt_x < SW'(MAX_PATTERN))
                            begin
                                p_we        = 1'b1;
                                p_waddr     = pcount_reg[PAW-1:0];
                                pcount_next = pcount_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_RUN:
                        begin
                            start_next = '0;
                            k_next     = '0;
                            idx_next   = '0;
                            found_next = 1'b0;
                            if (pcount_reg == '0)
                            begin
                                // An empty pattern always matches and removes nothing.
                                found_next = 1'b1;
                                state_next = ST_EMIT_RD;
                            end
                            else if (pcnt_x > tcnt_x)
                            begin
                                state_next = ST_EMIT_RD;
                            end
                            else
                            begin
                                state_next = ST_MATCH_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MATCH_RD:
            begin
                t_re       = 1'b1;
                t_raddr    = sum_sk[TAW-1:0];
                p_re       = 1'b1;
                p_raddr    = k_reg[PAW-1:0];
                state_next = ST_MATCH_CMP;
            end
            ST_MATCH_CMP:
            begin
                if (t_rdata_reg == p_rdata_reg)
                begin
                    if (k_x + 1'b1 == pcnt_x)
                    begin
                        found_next = 1'b1;
                        idx_next   = start_reg;
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_MATCH_RD;
                    end
                end
                else
                begin
                    k_next     = '0;
                    start_next = start_reg + 1'b1;
                    if (sum_next_start > tcnt_x)
                    begin
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_MATCH_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                if (sum_ip < tcnt_x)
                begin
                    t_re       = 1'b1;
                    t_raddr    = sum_ip[TAW-1:0];
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    tcount_next = TCW'(tcnt_x - pcnt_x);
                    idx_next    = '0;
                    state_next  = ST_EMIT_RD;
                end
            end
            ST_SHIFT_WR:
            begin
                t_we       = 1'b1;
                t_waddr    = idx_reg[TAW-1:0];
                t_wdata    = t_rdata_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_EMIT_RD:
            begin
                if (tcount_reg != '0)
                begin
                    t_re    = 1'b1;
                    t_raddr = idx_reg[TAW-1:0];
                end
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (tcount_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_value_next = t_rdata_reg;
                        out_empty_next = 1'b0;
                        out_last_next  = (idx_x + 1'b1 == tcnt_x);
                        idx_next       = idx_reg + 1'b1;
                        state_next     = out_last_next ? ST_IDLE : ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tcount_reg    <= '0;
            pcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tcount_reg <= tcount_next;
            pcount_reg <= pcount_next;
            ovf_reg    <= ovf_next;
            found_reg  <= found_next;
            start_reg  <= start_next;
            k_reg      <= k_next;
            idx_reg    <= idx_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
            out_found_reg <= found_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            target_mem[t_waddr] <= t_wdata;
        end
        if (t_re)
        begin
            t_rdata_reg <= target_mem[t_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pattern_mem[p_waddr] <= q_cmd.word;
        end
        if (p_re)
        begin
            p_rdata_reg <= pattern_mem[p_raddr];
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.value     = out_value_reg;
    assign result.last      = out_last_reg;
    assign result.found     = out_found_reg;
    assign result.empty_res = out_empty_reg;
    assign result.overflow  = out_ovf_reg;

endmodule

`default_nettype wire

@@ rtl/remove_first_subsequence.sv @@
// Top level: removes the first occurrence of a pattern from a stored sequence.
//
//   channel   role     items                       handshake
//   cmd       sink     op, word                    valid/ready
//   result    source   value, last, found,         valid/ready
//                      empty_res, overflow
//
// The back end takes clear and append items while idle; a four-entry
// queue lets the front keep taking items while a run is in progress.
// A run with T target words and P pattern words searches each start position,
// then compacts the target by moving the words after a match down, then emits
// the remaining words, holding on any stall on the result channel.
// Reset clears the counts and control state; store contents are not cleared.
`default_nettype none

module remove_first_subsequence import rfs_pkg::*;
#(
    parameter int MAX_TARGET  = 64,
    parameter int MAX_PATTERN = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    rfs_item_if.sink      cmd,
    rfs_result_if.source  result
);

    cmd_t          q_cmd;
    logic          q_valid;
    logic          q_pop;

    rfs_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    rfs_back
    #(
        .MAX_TARGET  (MAX_TARGET),
        .MAX_PATTERN (MAX_PATTERN)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ rtl/rfs_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module rfs_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [31:0] result_value,
    input logic               result_last,
    input logic               result_found,
    input logic               result_empty_res,
    input logic               result_overflow
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_value) && $stable(result_last)
            && $stable(result_found) && $stable(result_empty_res)
            && $stable(result_overflow))
        else $error("result payload changed while stalled");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_empty_res |-> result_last)
        else $error("empty result not marked last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_empty_res |-> result_value == 32'sd0)
        else $error("empty result carries a nonzero value");

endmodule

bind remove_first_subsequence rfs_checker u_rfs_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_value     (result.value),
    .result_last      (result.last),
    .result_found     (result.found),
    .result_empty_res (result.empty_res),
    .result_overflow  (result.overflow)
);

`default_nettype wire

@@ tb/remove_first_subsequence_tb.sv @@
// Self-checking testbench for remove_first_subsequence, with its own shadow copy of the stores.
`default_nettype none

module remove_first_subsequence_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfs_pkg::*;

    localparam int          TGT_CAP      = 64;
    localparam int          PAT_CAP      = 16;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef struct {
        logic signed [WORD_W-1:0] value;
        logic                     last;
        logic                     found;
        logic                     empty_res;
        logic                     overflow;
    } outcome_t;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] word;
        bit                       typed;
        outcome_t                 res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rfs_item_if   cmd_ch ();
    rfs_result_if res_ch ();

    remove_first_subsequence #(
        .MAX_TARGET  (TGT_CAP),
        .MAX_PATTERN (PAT_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    // Shadow copy of the block's stores.
    logic signed [WORD_W-1:0] sh_tgt [TGT_CAP];
    logic signed [WORD_W-1:0] sh_pat [PAT_CAP];
    int unsigned              sh_tgt_len;
    int unsigned              sh_pat_len;
    logic                     sh_ovf;

    outcome_t    owed_emits [$];
    stim_row_t   directed_rows [$];
    int unsigned fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned cycle_count  = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    bit          hold_req     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one accepted item to the shadow stores and queues the words a run emits.
    task automatic predict_emits(input logic [OP_W-1:0] op,
                                 input logic signed [WORD_W-1:0] word);
        int unsigned start;
        int unsigned k;
        int unsigned i;
        bit          hit;
        bit          match;
        outcome_t    o;
        case (op)
            OP_CLEAR:
            begin
                sh_tgt_len = 0;
                sh_pat_len = 0;
                sh_ovf     = 1'b0;
            end
            OP_APP_TARGET:
            begin
                if (sh_tgt_len < TGT_CAP)
                begin
                    sh_tgt[sh_tgt_len] = word;
                    sh_tgt_len++;
                end
                else
                    sh_ovf = 1'b1;
            end
            OP_APP_PATTERN:
            begin
                if (sh_pat_len < PAT_CAP)
                begin
                    sh_pat[sh_pat_len] = word;
                    sh_pat_len++;
                end
                else
                    sh_ovf = 1'b1;
            end
            OP_RUN:
            begin
                hit = (sh_pat_len == 0);
                if (!hit && sh_pat_len <= sh_tgt_len)
                begin
                    for (start = 0; start + sh_pat_len <= sh_tgt_len && !hit; start++)
                    begin
                        match = 1'b1;
                        for (k = 0; k < sh_pat_len; k++)
                            if (sh_tgt[start + k] != sh_pat[k])
                                match = 1'b0;
                        if (match)
                        begin
                            hit = 1'b1;
                            for (i = start; i + sh_pat_len < sh_tgt_len; i++)
                                sh_tgt[i] = sh_tgt[i + sh_pat_len];
                            sh_tgt_len -= sh_pat_len;
                        end
                    end
                end
                o.found     = hit;
                o.overflow  = sh_ovf;
                if (sh_tgt_len == 0)
                begin
                    o.value     = '0;
                    o.last      = 1'b1;
                    o.empty_res = 1'b1;
                    owed_emits.push_back(o);
                end
                else
                begin
                    o.empty_res = 1'b0;
                    for (i = 0; i < sh_tgt_len; i++)
                    begin
                        o.value = sh_tgt[i];
                        o.last  = (i + 1 == sh_tgt_len);
                        owed_emits.push_back(o);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic stim_row_t plain_row(input logic [OP_W-1:0] op,
                                            input logic signed [WORD_W-1:0] word);
        stim_row_t r;
        r.op    = op;
        r.word  = word;
        r.typed = 1'b0;
        r.res   = '{default: '0};
        return r;
    endfunction

    // A run with a single result whose fields are known up front.
    function automatic stim_row_t typed_row(input logic [OP_W-1:0] op,
                                            input logic signed [WORD_W-1:0] word,
                                            input logic signed [WORD_W-1:0] value,
                                            input logic found,
                                            input logic empty_res);
        stim_row_t r;
        r.op            = op;
        r.word          = word;
        r.typed         = 1'b1;
        r.res.value     = value;
        r.res.last      = 1'b1;
        r.res.found     = found;
        r.res.empty_res = empty_res;
        r.res.overflow  = 1'b0;
        return r;
    endfunction

    task automatic send_item(input stim_row_t r);
        int unsigned n0;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.op    = r.op;
        cmd_ch.word  = r.word;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        n0 = owed_emits.size();
        predict_emits(r.op, r.word);
        if (r.typed)
        begin
            while (owed_emits.size() > n0)
                void'(owed_emits.pop_back());
            owed_emits.push_back(r.res);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] word);
        send_item(plain_row(op, word));
    endtask

    // Mostly a narrow alphabet so that patterns match; full-range words exercise every bit.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0, 1:    return $urandom();
            2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return int'($urandom_range(3)) - 1;
        endcase
    endfunction

    // One well-formed sequence: clear, fill both stores, run, with some noise around it.
    task automatic run_scenario(input int unsigned n_tgt, input int unsigned n_pat);
        int unsigned s;
        int unsigned k;
        if ($urandom_range(9) != 0)
            send_op(OP_CLEAR, $urandom());
        repeat (n_tgt)
            send_op(OP_APP_TARGET, pick_word());
        if (n_pat <= sh_tgt_len && $urandom_range(9) < 6)
        begin
            s = $urandom_range(sh_tgt_len - n_pat);
            for (k = 0; k < n_pat; k++)
                send_op(OP_APP_PATTERN, sh_tgt[s + k]);
        end
        else
            repeat (n_pat)
                send_op(OP_APP_PATTERN, pick_word());
        send_op(OP_RUN, $urandom());
        if ($urandom_range(9) < 3)
            send_op(OP_RUN, $urandom());
        if ($urandom_range(9) < 2)
            repeat ($urandom_range(1, 3))
                send_op(OP_W'($urandom_range(int'(OP_RUN))), $urandom());
    endtask

    task automatic check_field(input string name, input logic signed [WORD_W-1:0] want,
                               input logic signed [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (owed_emits.size() == 0)
            begin
                $display("%0t: result with nothing expected, got value %0d last %0b found %0b %s",
                         $time, res_ch.value, res_ch.last, res_ch.found,
                         $sformatf("empty_res %0b overflow %0b",
                                   res_ch.empty_res, res_ch.overflow));
                fail_count++;
            end
            else
            begin
                want = owed_emits.pop_front();
                check_field("value", want.value, res_ch.value);
                check_field("last", WORD_W'(want.last), WORD_W'(res_ch.last));
                check_field("found", WORD_W'(want.found), WORD_W'(res_ch.found));
                check_field("empty_res", WORD_W'(want.empty_res), WORD_W'(res_ch.empty_res));
                check_field("overflow", WORD_W'(want.overflow), WORD_W'(res_ch.overflow));
            end
        end
    end

    // Result side: random stalls, plus one long hold-off that backs the block up.
    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left       = 0;
        hold_done       = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else
                res_ch.ready = ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time, owed_emits.size());
            $display("remove_first_subsequence_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned base;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op    = OP_CLEAR;
        cmd_ch.word  = '0;
        sh_tgt_len   = 0;
        sh_pat_len   = 0;
        sh_ovf       = 1'b0;
        send_gap_pct = 27;
        recv_gap_pct = 80;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty pattern after reset, pattern longer than an empty target, extremes.
        directed_rows.push_back(typed_row(OP_RUN, 0, 0, 1'b1, 1'b1));
        directed_rows.push_back(plain_row(OP_APP_PATTERN, 32'h7FFF_FFFF));
        directed_rows.push_back(typed_row(OP_RUN, 32'hFFFF_FFFF, 0, 1'b0, 1'b1));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 32'h8000_0000));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 32'h7FFF_FFFF));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 0));
        directed_rows.push_back(plain_row(OP_RUN, 0));
        directed_rows.push_back(plain_row(OP_RUN, 0));
        // The whole target removed leaves an empty result.
        directed_rows.push_back(plain_row(OP_CLEAR, 32'hFFFF_FFFF));
        directed_rows.push_back(plain_row(OP_APP_TARGET, -1));
        directed_rows.push_back(plain_row(OP_APP_PATTERN, -1));
        directed_rows.push_back(typed_row(OP_RUN, 0, 0, 1'b1, 1'b1));
        // Empty pattern leaves a nonempty target as it is.
        directed_rows.push_back(plain_row(OP_CLEAR, 0));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 5));
        directed_rows.push_back(typed_row(OP_RUN, 0, 5, 1'b1, 1'b0));
        directed_rows.push_back(plain_row(OP_APP_PATTERN, 5));
        directed_rows.push_back(plain_row(OP_APP_PATTERN, 6));
        directed_rows.push_back(typed_row(OP_RUN, 0, 5, 1'b0, 1'b0));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 6));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 5));
        directed_rows.push_back(plain_row(OP_RUN, 0));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 32'h5555_5555));
        directed_rows.push_back(plain_row(OP_APP_TARGET, 32'hAAAA_AAAA));
        directed_rows.push_back(plain_row(OP_RUN, 0));
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        base = items_sent;
        // Target filled past capacity, so the run reports overflow.
        run_scenario(TGT_CAP + 1, $urandom_range(1, 4));
        while (items_sent < base + 75)
            run_scenario($urandom_range(0, 12), $urandom_range(0, 4));

        send_gap_pct = 80;
        recv_gap_pct = 27;
        // Pattern filled past capacity.
        run_scenario(20, PAT_CAP + 1);
        while (items_sent < base + 115)
            run_scenario($urandom_range(0, 12), $urandom_range(0, 4));

        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_req     = 1'b1;
        while (items_sent < base + 140)
            run_scenario($urandom_range(0, 12), $urandom_range(0, 4));
        cmd_ch.valid = 1'b0;

        while (owed_emits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && owed_emits.size() == 0)
            $display("remove_first_subsequence_tb: done, clean");
        else
            $display("remove_first_subsequence_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
